@@ rtl/core/rtcm3_deframer_week_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// RTCM3 deframer week tracker: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RTCM3_DEFRAMER_WEEK_TRACKER_MACROS_SVH
`define RTCM3_DEFRAMER_WEEK_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDWT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/rdwt_pkg.sv @@
// ----------------------------------------------------------------------------
// RTCM3 deframer week tracker package
// Parser phase codes, frame constants and port widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdwt_pkg;

   // Parser phases.
   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_LEN_HI = 2'd1;
   localparam logic [1:0] PH_LEN_LO = 2'd2;
   localparam logic [1:0] PH_BODY   = 2'd3;

   // Frame framing constants.
   localparam logic [7:0]  PREAMBLE     = 8'hD3;
   localparam logic [7:0]  LEN_RSV_MASK = 8'hFC;
   localparam logic [10:0] CRC_BYTES    = 11'd3;

   // Positions of body bytes inside the frame.
   localparam logic [10:0] IDX_TYPE_HI = 11'd3;
   localparam logic [10:0] IDX_TYPE_LO = 11'd4;
   localparam logic [10:0] IDX_TOW_0   = 11'd6;
   localparam logic [10:0] IDX_TOW_1   = 11'd7;
   localparam logic [10:0] IDX_TOW_2   = 11'd8;
   localparam logic [10:0] IDX_TOW_3   = 11'd9;

   // GPS MSM recognition and week rollover.
   localparam logic [11:0] MSM_TYPE_LOW  = 12'd1071;
   localparam logic [11:0] MSM_TYPE_HIGH = 12'd1077;
   localparam logic [9:0]  MSM_MIN_PLEN  = 10'd4;
   localparam logic [29:0] ROLL_LIMIT    = 30'd302400000;
   localparam logic [15:0] RESET_WEEK    = 16'd1;

   // Result item layout in rsp_tdata.
   localparam int RSP_DATA_W = 72;
   localparam int TYPE_LSB   = 0;
   localparam int PLEN_LSB   = 12;
   localparam int TOW_LSB    = 22;
   localparam int WEEK_LSB   = 52;
   localparam int ADV_BIT    = 68;

endpackage

@@ rtl/core/rtcm3_deframer_week_tracker.sv @@
// A result item appears on rsp_* in the cycle after the frame's last byte is taken.
// The block takes one byte per cycle while req_tready is high; every byte updates only small counters and accumulators.
// req_tready drops only while a finished result waits and rsp_tready is low.
// Reset (synchronous, active high) returns the parser to preamble hunting,
// clears the time-of-week history and loads the GPS week with 1.
// ----------------------------------------------------------------------------
// RTCM3 deframer with GPS week tracking
// Finds RTCM3 frames in a byte stream, reports type and length per frame and
// follows the GPS week through the time of week of GPS MSM messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcm3_deframer_week_tracker (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration: start_week.
   input  logic                             csr_wr_en,
   input  logic [15:0]                      csr_wr_data,
   // Input stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] data_byte
   // Result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [11:0] message_type, [21:12] payload_length, [51:22] tow_ms,
   // [67:52] week_number, [68] week_advanced, [71:69] zero
   output logic [rdwt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser   // [0] is_gps_msm
);

   // Parser state.
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  len_hi_ff, len_hi_in;
   logic [10:0] bytes_left_ff, bytes_left_in;
   logic [10:0] byte_idx_ff, byte_idx_in;
   logic [9:0]  plen_ff, plen_in;
   logic [11:0] type_ff, type_in;
   logic [29:0] epoch_ff, epoch_in;

   // Week tracking state.
   logic [29:0] prev_tow_ff, prev_tow_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [15:0] week_ff, week_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rdwt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   logic        accept;
   logic        frame_end;
   logic        gps;
   logic        advance;
   logic [29:0] tow;
   logic [30:0] tow_drop;
   logic [9:0]  plen_new;
   logic [15:0] week_next;

   // The result register frees up when its item is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign plen_new   = {len_hi_ff, req_tdata};

   // Per-byte parse step.
   always_comb begin
      phase_in      = phase_ff;
      len_hi_in     = len_hi_ff;
      bytes_left_in = bytes_left_ff;
      byte_idx_in   = byte_idx_ff;
      plen_in       = plen_ff;
      type_in       = type_ff;
      epoch_in      = epoch_ff;
      frame_end     = 1'b0;
      case (phase_ff)
         rdwt_pkg::PH_HUNT: begin
            if (req_tdata == rdwt_pkg::PREAMBLE) phase_in = rdwt_pkg::PH_LEN_HI;
         end
         rdwt_pkg::PH_LEN_HI: begin
            if ((req_tdata & rdwt_pkg::LEN_RSV_MASK) == 8'd0) begin
               len_hi_in = req_tdata[1:0];
               phase_in  = rdwt_pkg::PH_LEN_LO;
            end else if (req_tdata != rdwt_pkg::PREAMBLE) begin
               phase_in = rdwt_pkg::PH_HUNT;
            end
         end
         rdwt_pkg::PH_LEN_LO: begin
            plen_in       = plen_new;
            bytes_left_in = {1'b0, plen_new} + rdwt_pkg::CRC_BYTES;
            byte_idx_in   = rdwt_pkg::IDX_TYPE_HI;
            type_in       = 12'd0;
            epoch_in      = 30'd0;
            phase_in      = rdwt_pkg::PH_BODY;
         end
         default: begin
            // Body byte: collect type and time-of-week bits by position.
            case (byte_idx_ff)
               rdwt_pkg::IDX_TYPE_HI: type_in  = {req_tdata, 4'd0};
               rdwt_pkg::IDX_TYPE_LO: type_in  = type_ff | {8'd0, req_tdata[7:4]};
               rdwt_pkg::IDX_TOW_0:   epoch_in = {req_tdata, 22'd0};
               rdwt_pkg::IDX_TOW_1:   epoch_in = epoch_ff | {8'd0, req_tdata, 14'd0};
               rdwt_pkg::IDX_TOW_2:   epoch_in = epoch_ff | {16'd0, req_tdata, 6'd0};
               rdwt_pkg::IDX_TOW_3:   epoch_in = epoch_ff | {24'd0, req_tdata[7:2]};
               default: ;
            endcase
            byte_idx_in = byte_idx_ff + 11'd1;
            if (bytes_left_ff != 11'd0) bytes_left_in = bytes_left_ff - 11'd1;
            if (bytes_left_ff <= 11'd1) begin
               frame_end = 1'b1;
               phase_in  = rdwt_pkg::PH_HUNT;
            end
         end
      endcase
   end

   // Frame classification and week rollover check.
   always_comb begin
      gps = (type_in >= rdwt_pkg::MSM_TYPE_LOW) && (type_in <= rdwt_pkg::MSM_TYPE_HIGH)
            && (plen_ff >= rdwt_pkg::MSM_MIN_PLEN);
      tow      = gps ? epoch_in : 30'd0;
      tow_drop = {1'b0, prev_tow_ff} - {1'b0, tow};
      advance  = gps && prev_valid_ff && !tow_drop[30] && (tow_drop[29:0] > rdwt_pkg::ROLL_LIMIT);
      week_next = advance ? week_ff + 16'd1 : week_ff;
   end

   // History and week update; a configuration write reloads the week.
   always_comb begin
      prev_tow_in   = prev_tow_ff;
      prev_valid_in = prev_valid_ff;
      week_in       = week_ff;
      if (accept && frame_end && gps) begin
         prev_tow_in   = tow;
         prev_valid_in = 1'b1;
         week_in       = week_next;
      end
      if (csr_wr_en) week_in = csr_wr_data;
   end

   // Result item assembly.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept && frame_end) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[rdwt_pkg::TYPE_LSB +: 12] = type_in;
         rsp_data_in[rdwt_pkg::PLEN_LSB +: 10] = plen_ff;
         rsp_data_in[rdwt_pkg::TOW_LSB  +: 30] = tow;
         rsp_data_in[rdwt_pkg::WEEK_LSB +: 16] = week_next;
         rsp_data_in[rdwt_pkg::ADV_BIT]        = advance;
         rsp_user_in  = gps;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rdwt_pkg::PH_HUNT;
         len_hi_ff     <= 2'd0;
         bytes_left_ff <= 11'd0;
         byte_idx_ff   <= 11'd0;
         plen_ff       <= 10'd0;
         type_ff       <= 12'd0;
         epoch_ff      <= 30'd0;
         prev_tow_ff   <= 30'd0;
         prev_valid_ff <= 1'b0;
         week_ff       <= rdwt_pkg::RESET_WEEK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            len_hi_ff     <= len_hi_in;
            bytes_left_ff <= bytes_left_in;
            byte_idx_ff   <= byte_idx_in;
            plen_ff       <= plen_in;
            type_ff       <= type_in;
            epoch_ff      <= epoch_in;
         end
         prev_tow_ff   <= prev_tow_in;
         prev_valid_ff <= prev_valid_in;
         week_ff       <= week_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ rtl/core/rdwt_checker.sv @@
// ----------------------------------------------------------------------------
// RTCM3 deframer week tracker port checker
// Watches the top-level ports and checks result items against the handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rtcm3_deframer_week_tracker_macros.svh"

module rdwt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rdwt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   logic        stall_out;
   logic [11:0] msg_kind;
   logic [9:0]  msg_plen;
   logic [29:0] msg_tow;
   logic        msg_adv;

   assign stall_out = rsp_tvalid && !rsp_tready;
   assign msg_kind  = rsp_tdata[rdwt_pkg::TYPE_LSB +: 12];
   assign msg_plen  = rsp_tdata[rdwt_pkg::PLEN_LSB +: 10];
   assign msg_tow   = rsp_tdata[rdwt_pkg::TOW_LSB +: 30];
   assign msg_adv   = rsp_tdata[rdwt_pkg::ADV_BIT];

   // A waiting result item holds its contents.
   `RDWT_ASSERT_NEXT(a_rsp_hold, clock, reset, stall_out,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "result item changed while stalled")

   // A new result item always follows an accepted input item.
   `RDWT_ASSERT_SAME(a_rsp_cause, clock, reset, $rose(rsp_tvalid),
      $past(req_tvalid && req_tready),
      "result item without an accepted input item")

   // The input side is never held off while the result register is empty.
   `RDWT_ASSERT_SAME(a_req_free, clock, reset, !rsp_tvalid, req_tready,
      "input stalled with empty result register")

   // Non-GPS frames carry no time of week and never advance the week.
   `RDWT_ASSERT_SAME(a_non_gps, clock, reset, rsp_tvalid && !rsp_tuser,
      msg_tow == 30'd0 && !msg_adv,
      "time of week or week advance on a non-GPS frame")

   // GPS frames have an MSM type and a long enough payload.
   `RDWT_ASSERT_SAME(a_gps_kind, clock, reset, rsp_tvalid && rsp_tuser,
      msg_kind >= rdwt_pkg::MSM_TYPE_LOW && msg_kind <= rdwt_pkg::MSM_TYPE_HIGH
      && msg_plen >= rdwt_pkg::MSM_MIN_PLEN,
      "GPS flag on a frame that is not GPS MSM")

endmodule

bind rtcm3_deframer_week_tracker rdwt_checker u_rdwt_checker (.*);

@@ bench/rtcm3_deframer_week_tracker_test.sv @@
// ----------------------------------------------------------------------------
// RTCM3 deframer week tracker testbench
// Feeds byte streams of well-formed, short and broken RTCM3 frames with
// random gaps and result back-pressure. A local parser predicts one report
// per completed frame, and each report is checked field by field as it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcm3_deframer_week_tracker_test;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_BYTES   = 100;
   localparam int WEEK_MS       = 604800000;
   localparam logic [10:0] MIN_MSM_FRAME = 11'd10;
   localparam logic [10:0] FRAME_OVERHEAD = 11'd6;

   // One frame report as it leaves the block.
   typedef struct packed {
      logic [11:0] kind;
      logic [9:0]  plen;
      logic        gps;
      logic [29:0] tow;
      logic [15:0] week;
      logic        advanced;
   } frame_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [15:0]            csr_wr_data = 16'd0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'd0;   // [7:0] data_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [11:0] message_type, [21:12] payload_length, [51:22] tow_ms,
   // [67:52] week_number, [68] week_advanced, [71:69] zero
   logic [rdwt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;          // [0] is_gps_msm

   // Stream bytes waiting for the driver, and reports waiting for the block.
   logic [7:0]       pending_bytes[$];
   frame_report_type expected_reports[$];
   int               bytes_queued = 0;
   int               bytes_taken = 0;
   int               error_count = 0;
   int               cycle_count = 0;
   int unsigned      tow_cursor = 0;

   // Local copy of the parser state.
   logic [1:0]    parse_phase;
   logic [1:0]    len_high;
   logic [10:0]   bytes_left;
   logic [10:0]   byte_index;
   logic [10:0]   frame_bytes;
   logic [11:0]   type_acc;
   logic [29:0]   tow_acc;
   logic [29:0]   last_tow;
   logic          last_tow_valid;
   logic [15:0]   week;

   // Sender and receiver pacing.
   int            gap_left;
   int            burst_left;
   logic [31:0]   stall_pattern;
   int            pattern_age;

   rtcm3_deframer_week_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Advance the parser by one stream byte; queue a report when a frame ends.
   task automatic parse_byte(input logic [7:0] b);
      frame_report_type report;
      case (parse_phase)
         rdwt_pkg::PH_HUNT: begin
            if (b == rdwt_pkg::PREAMBLE) parse_phase = rdwt_pkg::PH_LEN_HI;
         end
         rdwt_pkg::PH_LEN_HI: begin
            if ((b & rdwt_pkg::LEN_RSV_MASK) == 8'd0) begin
               len_high = b[1:0];
               parse_phase = rdwt_pkg::PH_LEN_LO;
            end else if (b != rdwt_pkg::PREAMBLE) begin
               parse_phase = rdwt_pkg::PH_HUNT;
            end
         end
         rdwt_pkg::PH_LEN_LO: begin
            frame_bytes = {1'b0, len_high, b} + FRAME_OVERHEAD;
            bytes_left = {1'b0, len_high, b} + rdwt_pkg::CRC_BYTES;
            byte_index = rdwt_pkg::IDX_TYPE_HI;
            type_acc = '0;
            tow_acc = '0;
            parse_phase = rdwt_pkg::PH_BODY;
         end
         default: begin
            case (byte_index)
               rdwt_pkg::IDX_TYPE_HI: type_acc = {b, 4'h0};
               rdwt_pkg::IDX_TYPE_LO: type_acc = type_acc | 12'(b >> 4);
               rdwt_pkg::IDX_TOW_0:   tow_acc = {b, 22'd0};
               rdwt_pkg::IDX_TOW_1:   tow_acc = tow_acc | (30'(b) << 14);
               rdwt_pkg::IDX_TOW_2:   tow_acc = tow_acc | (30'(b) << 6);
               rdwt_pkg::IDX_TOW_3:   tow_acc = tow_acc | 30'(b >> 2);
               default: ;
            endcase
            byte_index = byte_index + 11'd1;
            if (bytes_left != 11'd0) bytes_left = bytes_left - 11'd1;
            if (bytes_left == 11'd0) begin
               parse_phase = rdwt_pkg::PH_HUNT;
               report.gps = (type_acc >= rdwt_pkg::MSM_TYPE_LOW) &&
                            (type_acc <= rdwt_pkg::MSM_TYPE_HIGH) &&
                            (frame_bytes >= MIN_MSM_FRAME);
               report.tow = report.gps ? tow_acc : 30'd0;
               report.advanced = 1'b0;
               // A large backward jump in time of week means a new GPS week.
               if (report.gps) begin
                  if (last_tow_valid && last_tow > report.tow &&
                      (last_tow - report.tow) > rdwt_pkg::ROLL_LIMIT) begin
                     week = week + 16'd1;
                     report.advanced = 1'b1;
                  end
                  last_tow = report.tow;
                  last_tow_valid = 1'b1;
               end
               report.kind = type_acc;
               report.plen = 10'(frame_bytes - FRAME_OVERHEAD);
               report.week = week;
               expected_reports.push_back(report);
            end
         end
      endcase
   endtask

   // Driver: sends queued bytes in bursts and tracks what the block accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
         parse_phase = rdwt_pkg::PH_HUNT;
         len_high = '0;
         bytes_left = '0;
         byte_index = '0;
         frame_bytes = '0;
         type_acc = '0;
         tow_acc = '0;
         last_tow = '0;
         last_tow_valid = 1'b0;
         week = rdwt_pkg::RESET_WEEK;
      end else begin
         if (csr_wr_en) begin
            week = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata);
            bytes_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0 || pending_bytes.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_bytes.pop_front();
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end
         end
      end
   end

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Monitor: checks each accepted report and stalls on a rotating pattern.
   always @(posedge clock) begin
      frame_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_pattern = '1;
         pattern_age = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none, actual %h user %b",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("message_type", 32'(want.kind),
                           32'(rsp_tdata[rdwt_pkg::TYPE_LSB +: 12]));
               check_field("payload_length", 32'(want.plen),
                           32'(rsp_tdata[rdwt_pkg::PLEN_LSB +: 10]));
               check_field("is_gps_msm", 32'(want.gps), 32'(rsp_tuser));
               check_field("tow_ms", 32'(want.tow),
                           32'(rsp_tdata[rdwt_pkg::TOW_LSB +: 30]));
               check_field("week_number", 32'(want.week),
                           32'(rsp_tdata[rdwt_pkg::WEEK_LSB +: 16]));
               check_field("week_advanced", 32'(want.advanced),
                           32'(rsp_tdata[rdwt_pkg::ADV_BIT]));
               check_field("padding", 32'd0,
                           32'(rsp_tdata[rdwt_pkg::RSP_DATA_W-1:rdwt_pkg::ADV_BIT+1]));
            end
         end
         // When the pattern age runs out, pick a new pattern, sometimes one with no stalls.
         if (pattern_age == 0) begin
            pattern_age = 31;
            if ($urandom_range(0, 3) == 0) stall_pattern = '1;
            else stall_pattern = $urandom | $urandom;
         end else begin
            pattern_age--;
         end
         stall_pattern = {stall_pattern[30:0], stall_pattern[31]};
         rsp_tready <= stall_pattern[0];
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Queue one complete frame; unused payload and CRC bytes are random.
   task automatic add_frame(input logic [9:0] plen, input logic [11:0] mtype,
                            input logic [29:0] tow);
      logic [10:0] pos;
      logic [7:0]  b;
      for (int i = 0; i < int'(plen) + 6; i++) begin
         pos = 11'(i);
         b = 8'($urandom);
         case (pos)
            11'd0:                 b = rdwt_pkg::PREAMBLE;
            11'd1:                 b = {6'd0, plen[9:8]};
            11'd2:                 b = plen[7:0];
            rdwt_pkg::IDX_TYPE_HI: b = mtype[11:4];
            rdwt_pkg::IDX_TYPE_LO: b = {mtype[3:0], b[3:0]};
            rdwt_pkg::IDX_TOW_0:   b = tow[29:22];
            rdwt_pkg::IDX_TOW_1:   b = tow[21:14];
            rdwt_pkg::IDX_TOW_2:   b = tow[13:6];
            rdwt_pkg::IDX_TOW_3:   b = {tow[5:0], b[1:0]};
            default: ;
         endcase
         queue_byte(b);
      end
   endtask

   // Mostly well-formed frames with a moving time of week, plus noise and
   // broken headers.
   task automatic add_random_traffic(input int byte_goal);
      int          first;
      int          pick;
      logic [9:0]  plen;
      logic [11:0] mtype;
      logic [29:0] tow;
      first = bytes_queued;
      while (bytes_queued - first < byte_goal) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            if ($urandom_range(0, 29) == 0) plen = 10'($urandom_range(24, 200));
            else plen = 10'($urandom_range(0, 20));
            pick = $urandom_range(0, 9);
            if (pick < 6) mtype = 12'($urandom_range(1071, 1077));
            else if (pick == 6) mtype = ($urandom_range(0, 1) == 0) ? 12'd1070 : 12'd1078;
            else mtype = 12'($urandom);
            if ($urandom_range(0, 7) == 0) begin
               tow = 30'($urandom);
            end else begin
               tow_cursor = (tow_cursor + $urandom_range(0, 100000000)) % WEEK_MS;
               tow = 30'(tow_cursor);
            end
            add_frame(plen, mtype, tow);
         end else if (pick < 17) begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
         end else if (pick < 19) begin
            // Preamble followed by a length byte with reserved bits set.
            queue_byte(rdwt_pkg::PREAMBLE);
            queue_byte(8'($urandom_range(4, 255)));
         end else begin
            // Repeated preambles ahead of a real frame.
            repeat ($urandom_range(1, 3)) queue_byte(rdwt_pkg::PREAMBLE);
         end
      end
   endtask

   task automatic write_start_week(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until all bytes are taken and every report has come back.
   task automatic wait_idle();
      while (bytes_taken != bytes_queued || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus: directed frames first, then random phases at several weeks.
   initial begin
      logic [15:0] phase_weeks[4];
      phase_weeks[0] = rdwt_pkg::RESET_WEEK;
      phase_weeks[1] = 16'd0;
      phase_weeks[2] = 16'hFFFF;
      phase_weeks[3] = 16'($urandom_range(2, 65534));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Top week value, so the first rollover wraps the counter.
      write_start_week(16'hFFFF);
      add_frame(10'd4, 12'd1071, 30'h3FFF_FFFF);
      add_frame(10'd4, 12'd1077, 30'd0);
      add_frame(10'd5, 12'd1074, rdwt_pkg::ROLL_LIMIT);
      add_frame(10'd6, 12'd1072, 30'd0);
      add_frame(10'd4, 12'd1073, rdwt_pkg::ROLL_LIMIT + 30'd1);
      add_frame(10'd4, 12'd1076, 30'd0);
      // Frame too short for an MSM, and types just outside the MSM range.
      add_frame(10'd3, 12'd1075, 30'd0);
      add_frame(10'd8, 12'd1070, 30'h3FFF_FFFF);
      add_frame(10'd8, 12'd1078, 30'h3FFF_FFFF);
      // Payloads too short to hold the type.
      add_frame(10'd0, 12'hFFF, 30'd0);
      add_frame(10'd1, 12'h000, 30'd0);
      // Bad length bytes, and a preamble in the length position.
      queue_byte(rdwt_pkg::PREAMBLE);
      queue_byte(8'h04);
      queue_byte(rdwt_pkg::PREAMBLE);
      queue_byte(8'hFF);
      queue_byte(rdwt_pkg::PREAMBLE);
      queue_byte(rdwt_pkg::PREAMBLE);
      add_frame(10'd2, 12'd1005, 30'd0);
      add_frame(10'h1FF, 12'd1071, 30'd1000);
      wait_idle();

      foreach (phase_weeks[p]) begin
         write_start_week(phase_weeks[p]);
         add_random_traffic(PHASE_BYTES);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
